// ===== src/chs_pkg.sv =====
package chs_pkg;

    localparam int PTR_W    = 7;
    localparam int KEY_IN_W = 32;
    localparam int BKT_W    = 6;
    localparam int CMD_W    = 2;
    localparam int ST_W     = 2;

    // all-ones link code marks the end of a chain or an empty list
    localparam logic [PTR_W-1:0] NIL = '1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_IN_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BKT_W-1:0] bucket;
    } t_res;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } t_bkt_ent;

    typedef struct packed {
        logic             rd;
        logic             we;
        logic [BKT_W-1:0] addr;
        t_bkt_ent         ent;
    } t_bkt_cmd;

    typedef struct packed {
        logic             rd;
        logic             key_we;
        logic             link_we;
        logic [PTR_W-1:0] rd_addr;
        logic [PTR_W-1:0] wr_addr;
        logic [PTR_W-1:0] wr_link;
    } t_node_cmd;

endpackage

// ===== src/chs_mod.sv =====
module chs_mod #(
    parameter int NUM_BUCKETS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chs_pkg::KEY_IN_W-1:0] i_key,
    output logic                         o_done,
    output logic [chs_pkg::BKT_W-1:0]    o_bucket
);
    import chs_pkg::*;

    localparam int NIB_STEPS = KEY_IN_W / 4;
    localparam int CNT_W     = $clog2(NIB_STEPS);
    localparam int RW        = BKT_W + 4;
    localparam logic [RW-1:0] MODV = RW'(NUM_BUCKETS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [KEY_IN_W-1:0] r_shift;
    logic [BKT_W-1:0]    r_rem;
    logic [RW-1:0]       n_wide;

    // one nibble per cycle: shift it in, then reduce by 8m, 4m, 2m, m
    always_comb begin
        n_wide = {r_rem, r_shift[KEY_IN_W-1 -: 4]};
        for (int j = 3; j >= 0; j--) begin
            if (n_wide >= (MODV << j)) begin
                n_wide = n_wide - (MODV << j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NIB_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_key;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << 4;
            r_rem   <= n_wide[BKT_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

// ===== src/chs_bkt_ram.sv =====
module chs_bkt_ram #(
    parameter int NUM_BUCKETS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chs_pkg::t_bkt_cmd i_cmd,
    output chs_pkg::t_bkt_ent o_ent
);
    import chs_pkg::*;

    localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    t_bkt_ent               mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    t_bkt_ent               r_rd_ent;
    logic                   r_rd_vld;
    logic [BAW-1:0]         w_addr;

    assign w_addr = i_cmd.addr[BAW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[w_addr] <= i_cmd.ent;
        end
        if (i_cmd.rd) begin
            r_rd_ent <= mem[w_addr];
        end
    end

    // a bucket never written reads as an empty chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.we) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_valid[w_addr];
            end
        end
    end

    assign o_ent = r_rd_vld ? r_rd_ent : t_bkt_ent'{head: NIL, tail: NIL};

endmodule

// ===== src/chs_node_ram.sv =====
module chs_node_ram #(
    parameter int POOL_SIZE = 64,
    parameter int KW        = 32
) (
    input  logic               i_clk,
    input  chs_pkg::t_node_cmd i_cmd,
    input  logic [KW-1:0]      i_wr_key,
    output logic [KW-1:0]      o_rd_key,
    output logic [chs_pkg::PTR_W-1:0] o_rd_link
);
    import chs_pkg::*;

    localparam int PAW = $clog2(POOL_SIZE);

    logic [KW-1:0]    mem_key  [POOL_SIZE];
    logic [PTR_W-1:0] mem_link [POOL_SIZE];
    logic [KW-1:0]    r_rd_key;
    logic [PTR_W-1:0] r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            mem_key[i_cmd.wr_addr[PAW-1:0]] <= i_wr_key;
        end
        if (i_cmd.link_we) begin
            mem_link[i_cmd.wr_addr[PAW-1:0]] <= i_cmd.wr_link;
        end
        if (i_cmd.rd) begin
            r_rd_key  <= mem_key[i_cmd.rd_addr[PAW-1:0]];
            r_rd_link <= mem_link[i_cmd.rd_addr[PAW-1:0]];
        end
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_link = r_rd_link;

endmodule

// ===== src/chained_hash_set.sv =====
// a request runs through nibble-serial key mod and one bucket memory read, then
// S_FREE, S_INS1 and S_INS2 on insert (S_FREE and S_INS2 only when needed), or
// one chain node read per step on search and remove, then S_REM1 and S_REM2
// (S_REM2 only when needed) on remove. busy drops as o_done rises, so the next
// start can transfer at the edge that takes the result, and not while busy.
// reset empties all buckets and the pool; the receiver cannot stall o_done.
module chained_hash_set #(
    parameter int NUM_BUCKETS = 10,
    parameter int POOL_SIZE   = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  chs_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output chs_pkg::t_res o_res
);
    import chs_pkg::*;

    localparam int KW = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_HASH = 10'b0000000010,
        S_DISP = 10'b0000000100,
        S_FREE = 10'b0000001000,
        S_INS1 = 10'b0000010000,
        S_INS2 = 10'b0000100000,
        S_WALK = 10'b0001000000,
        S_REM1 = 10'b0010000000,
        S_REM2 = 10'b0100000000,
        S_FAIL = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [KW-1:0]    r_key, n_key;
    logic [BKT_W-1:0] r_bkt, n_bkt;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_node, n_node;
    logic [PTR_W-1:0] r_prev, n_prev;
    logic [PTR_W-1:0] r_next, n_next;
    logic [PTR_W-1:0] r_steps, n_steps;
    logic [PTR_W-1:0] r_free, n_free;
    logic [PTR_W-1:0] r_fresh, n_fresh;
    logic             r_done, n_done;
    t_res             r_res, n_res;

    logic                w_hash_start;
    logic [KEY_IN_W-1:0] w_hash_key;
    logic                w_hash_done;
    logic [BKT_W-1:0]    w_hash_bkt;
    t_bkt_cmd            w_bcmd;
    t_bkt_ent            w_bent;
    t_node_cmd           w_ncmd;
    logic [KW-1:0]       w_rd_key;
    logic [PTR_W-1:0]    w_rd_link;
    logic                w_fin;
    logic [ST_W-1:0]     w_fin_st;

    function automatic logic f_valid(input logic [PTR_W-1:0] p);
        return p < PTR_W'(POOL_SIZE);
    endfunction

    chs_mod #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_key    (w_hash_key),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bkt)
    );

    chs_bkt_ram #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_bkt_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bcmd),
        .o_ent   (w_bent)
    );

    chs_node_ram #(
        .POOL_SIZE(POOL_SIZE),
        .KW       (KW)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_cmd     (w_ncmd),
        .i_wr_key  (r_key),
        .o_rd_key  (w_rd_key),
        .o_rd_link (w_rd_link)
    );

    always_comb begin
        w_hash_key         = '0;
        w_hash_key[KW-1:0] = i_req.key[KW-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_bkt        = r_bkt;
        n_head       = r_head;
        n_tail       = r_tail;
        n_node       = r_node;
        n_prev       = r_prev;
        n_next       = r_next;
        n_steps      = r_steps;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_done       = 1'b0;
        n_res        = r_res;
        w_hash_start = 1'b0;
        w_bcmd       = '0;
        w_ncmd       = '0;
        w_fin        = 1'b0;
        w_fin_st     = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd        = i_req.cmd;
                    n_key        = i_req.key[KW-1:0];
                    w_hash_start = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_bkt       = w_hash_bkt;
                    w_bcmd.rd   = 1'b1;
                    w_bcmd.addr = w_hash_bkt;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_head = w_bent.head;
                n_tail = w_bent.tail;
                case (r_cmd)
                    CMD_INSERT: begin
                        // released nodes are reused before fresh ones
                        if (f_valid(r_free)) begin
                            w_ncmd.rd      = 1'b1;
                            w_ncmd.rd_addr = r_free;
                            n_state        = S_FREE;
                        end else if (r_fresh < PTR_W'(POOL_SIZE)) begin
                            n_node  = r_fresh;
                            n_fresh = r_fresh + PTR_W'(1);
                            n_state = S_INS1;
                        end else begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_FULL;
                        end
                    end
                    CMD_SEARCH, CMD_REMOVE: begin
                        if (f_valid(w_bent.head)) begin
                            w_ncmd.rd      = 1'b1;
                            w_ncmd.rd_addr = w_bent.head;
                            n_node         = w_bent.head;
                            n_prev         = NIL;
                            n_steps        = '0;
                            n_state        = S_WALK;
                        end else begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_MISS;
                        end
                    end
                    default: begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_MISS;
                    end
                endcase
            end
            S_FREE: begin
                n_node  = r_free;
                n_free  = w_rd_link;
                n_state = S_INS1;
            end
            S_INS1: begin
                w_ncmd.key_we  = 1'b1;
                w_ncmd.link_we = 1'b1;
                w_ncmd.wr_addr = r_node;
                w_ncmd.wr_link = NIL;
                w_bcmd.we       = 1'b1;
                w_bcmd.addr     = r_bkt;
                w_bcmd.ent.tail = r_node;
                if (f_valid(r_head) && f_valid(r_tail)) begin
                    w_bcmd.ent.head = r_head;
                    n_state         = S_INS2;
                end else begin
                    w_bcmd.ent.head = r_node;
                    w_fin           = 1'b1;
                    w_fin_st        = ST_OK;
                end
            end
            S_INS2: begin
                // append behind the old tail
                w_ncmd.link_we = 1'b1;
                w_ncmd.wr_addr = r_tail;
                w_ncmd.wr_link = r_node;
                w_fin          = 1'b1;
                w_fin_st       = ST_OK;
            end
            S_WALK: begin
                if (w_rd_key == r_key) begin
                    if (r_cmd == CMD_SEARCH) begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_OK;
                    end else begin
                        n_next  = w_rd_link;
                        n_state = S_REM1;
                    end
                end else if (r_steps != PTR_W'(POOL_SIZE - 1) && f_valid(w_rd_link)) begin
                    w_ncmd.rd      = 1'b1;
                    w_ncmd.rd_addr = w_rd_link;
                    n_prev         = r_node;
                    n_node         = w_rd_link;
                    n_steps        = r_steps + PTR_W'(1);
                end else begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_MISS;
                end
            end
            S_REM1: begin
                // push the node onto the free list and fix head and tail
                w_ncmd.link_we = 1'b1;
                w_ncmd.wr_addr = r_node;
                w_ncmd.wr_link = r_free;
                n_free         = r_node;
                w_bcmd.we      = 1'b1;
                w_bcmd.addr    = r_bkt;
                if (f_valid(r_prev)) begin
                    w_bcmd.ent.head = r_head;
                end else begin
                    w_bcmd.ent.head = f_valid(r_next) ? r_next : NIL;
                end
                w_bcmd.ent.tail = (r_tail == r_node) ? r_prev : r_tail;
                if (f_valid(r_prev)) begin
                    n_state = S_REM2;
                end else begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_OK;
                end
            end
            S_REM2: begin
                w_ncmd.link_we = 1'b1;
                w_ncmd.wr_addr = r_prev;
                w_ncmd.wr_link = r_next;
                w_fin          = 1'b1;
                w_fin_st       = ST_OK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_done       = 1'b1;
            n_res.status = w_fin_st;
            n_res.bucket = r_bkt;
            n_state      = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= NIL;
            r_fresh <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_bkt   <= n_bkt;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_node  <= n_node;
        r_prev  <= n_prev;
        r_next  <= n_next;
        r_steps <= n_steps;
        r_res   <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_fell_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without a result transfer");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not occupy the block");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= PTR_W'(POOL_SIZE))
        else $error("fresh node count ran past the pool");

    a_full_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_FULL) |->
            (r_fresh == PTR_W'(POOL_SIZE) && !f_valid(r_free)))
        else $error("pool full reported with nodes still available");

    a_hash_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> (r_state == S_HASH))
        else $error("key mod finished outside the hash phase");

endmodule

// ===== verif/tb_chained_hash_set.sv =====
module tb_chained_hash_set;
    import chs_pkg::*;

    localparam int NUM_BUCKETS = 10;
    localparam int POOL_SIZE   = 64;
    localparam int KEY_WIDTH   = 32;

    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int HOT_KEYS    = 24;
    localparam int PHASE_LEN   = 105;
    localparam int PHASE_PAIRS = 3;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_WAIT  = POOL_SIZE + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        t_req req;
        bit   typed;
        t_res res;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    // shadow copy of the hash table
    logic [PTR_W-1:0]     head_of [NUM_BUCKETS] = '{default: NIL};
    logic [PTR_W-1:0]     tail_of [NUM_BUCKETS] = '{default: NIL};
    logic [KEY_WIDTH-1:0] key_of  [POOL_SIZE];
    logic [PTR_W-1:0]     link_of [POOL_SIZE];
    logic [PTR_W-1:0]     free_top   = NIL;
    int unsigned          fresh_next = 0;

    t_res        pending_res [$];
    bit          failed      = 1'b0;
    bit          no_idle     = 1'b0;
    int unsigned cycle_count = 0;
    logic [31:0] hot_keys [HOT_KEYS];

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{CMD_SEARCH, 32'h0000_0000}, 1'b1, '{ST_MISS, 6'd0}},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF}, 1'b1, '{ST_MISS, 6'd5}},
        '{'{CMD_NONE,   32'h1234_5677}, 1'b1, '{ST_MISS, 6'd5}},
        '{'{CMD_INSERT, 32'h0000_0000}, 1'b1, '{ST_OK,   6'd0}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,   6'd5}},
        '{'{CMD_INSERT, 32'd10},        1'b0, '0},
        '{'{CMD_INSERT, 32'd20},        1'b0, '0},
        '{'{CMD_INSERT, 32'd10},        1'b0, '0},
        '{'{CMD_SEARCH, 32'd10},        1'b0, '0},
        '{'{CMD_SEARCH, 32'd30},        1'b1, '{ST_MISS, 6'd0}},
        '{'{CMD_REMOVE, 32'd20},        1'b0, '0},
        '{'{CMD_REMOVE, 32'd10},        1'b0, '0},
        '{'{CMD_SEARCH, 32'd10},        1'b0, '0},
        '{'{CMD_REMOVE, 32'd10},        1'b0, '0},
        '{'{CMD_REMOVE, 32'd0},         1'b0, '0},
        '{'{CMD_SEARCH, 32'd0},         1'b1, '{ST_MISS, 6'd0}},
        '{'{CMD_INSERT, 32'h8000_0000}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF}, 1'b1, '{ST_MISS, 6'd5}},
        '{'{CMD_NONE,   32'hFFFF_FFFF}, 1'b1, '{ST_MISS, 6'd5}},
        '{'{CMD_INSERT, 32'hFFFF_FFF6}, 1'b0, '0},
        '{'{CMD_INSERT, 32'd5},         1'b0, '0},
        '{'{CMD_SEARCH, 32'h8000_0000}, 1'b0, '0}
    };

    chained_hash_set #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .POOL_SIZE  (POOL_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // applies one request to the shadow table and returns its result
    function automatic t_res hash_set_apply(t_req req);
        logic [KEY_WIDTH-1:0] k;
        int unsigned          b;
        int                   steps;
        logic [PTR_W-1:0]     cur;
        logic [PTR_W-1:0]     prev;
        logic [PTR_W-1:0]     hit;
        logic [PTR_W-1:0]     nxt;
        logic [PTR_W-1:0]     n;
        t_res                 res;
        k          = req.key[KEY_WIDTH-1:0];
        b          = k % NUM_BUCKETS;
        res.bucket = BKT_W'(b);
        res.status = ST_MISS;
        // first match in chain order, bounded against broken links
        cur  = head_of[b];
        prev = NIL;
        hit  = NIL;
        for (steps = 0; steps < POOL_SIZE && cur < POOL_SIZE && hit == NIL; steps++) begin
            if (key_of[cur] == k) begin
                hit = cur;
            end else begin
                prev = cur;
                cur  = link_of[cur];
            end
        end
        case (req.cmd)
            CMD_INSERT: begin
                n = NIL;
                if (free_top < POOL_SIZE) begin
                    n        = free_top;
                    free_top = link_of[n];
                end else if (fresh_next < POOL_SIZE) begin
                    n          = PTR_W'(fresh_next);
                    fresh_next = fresh_next + 1;
                end
                if (n == NIL) begin
                    res.status = ST_FULL;
                end else begin
                    key_of[n]  = k;
                    link_of[n] = NIL;
                    if (head_of[b] < POOL_SIZE && tail_of[b] < POOL_SIZE)
                        link_of[tail_of[b]] = n;
                    else
                        head_of[b] = n;
                    tail_of[b] = n;
                    res.status = ST_OK;
                end
            end
            CMD_SEARCH: begin
                if (hit != NIL)
                    res.status = ST_OK;
            end
            CMD_REMOVE: begin
                if (hit != NIL) begin
                    nxt = link_of[hit];
                    if (prev < POOL_SIZE)
                        link_of[prev] = nxt;
                    else
                        head_of[b] = (nxt < POOL_SIZE) ? nxt : NIL;
                    if (tail_of[b] == hit)
                        tail_of[b] = prev;
                    link_of[hit] = free_top;
                    free_top     = hit;
                    res.status   = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // waits a random gap unless no_idle is set, then holds the request until the transfer
    task automatic issue_request(t_req req, bit typed, t_res typed_res);
        int   gap;
        t_res pred;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = hash_set_apply(req);
        pending_res = {pending_res, (typed ? typed_res : pred)};
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result: status %0d bucket %0d",
                         $time, o_res.status, o_res.bucket);
                failed = 1'b1;
            end else begin
                want = pending_res.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_res.status);
                    failed = 1'b1;
                end
                if (o_res.bucket !== want.bucket) begin
                    $display("%0t: bucket mismatch: expected %0d actual %0d",
                             $time, want.bucket, o_res.bucket);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chained_hash_set verification failed");
            $finish;
        end
    end

    initial begin
        int          row;
        int          pair;
        int          half;
        int          i;
        int          h;
        int unsigned roll;
        int unsigned residue;
        bit          same_bucket;
        t_req        req;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
            issue_request(dir_rows[row].req, dir_rows[row].typed, dir_rows[row].res);

        // each pair fills the pool past full from a hot key set, then drains it
        for (pair = 0; pair < PHASE_PAIRS; pair++) begin
            same_bucket = (pair == 1);
            residue     = $urandom_range(0, NUM_BUCKETS - 1);
            for (h = 0; h < HOT_KEYS; h++)
                hot_keys[h] = same_bucket ? ($urandom_range(0, 429496728) * 10 + residue)
                                          : $urandom();
            for (half = 0; half < 2; half++) begin
                no_idle = ($urandom_range(0, 3) == 0);
                for (i = 0; i < PHASE_LEN; i++) begin
                    roll = $urandom_range(0, 99);
                    if (half == 0)
                        req.cmd = (roll < 80) ? CMD_INSERT :
                                  (roll < 90) ? CMD_SEARCH :
                                  (roll < 98) ? CMD_REMOVE : CMD_NONE;
                    else
                        req.cmd = (roll < 75) ? CMD_REMOVE :
                                  (roll < 90) ? CMD_SEARCH :
                                  (roll < 98) ? CMD_INSERT : CMD_NONE;
                    req.key = ($urandom_range(0, 99) < 85)
                              ? hot_keys[$urandom_range(0, HOT_KEYS - 1)] : $urandom();
                    issue_request(req, 1'b0, '0);
                end
            end
        end
        start <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed)
            $display("chained_hash_set verification clean");
        else
            $display("chained_hash_set verification failed");
        $finish;
    end

endmodule
